// File: rtl/class_aware_box_nms_unit_macros.svh
// Assertion macros used by the box suppression top level.
// Each macro expects signals named clk and rst in the including scope.
`ifndef CLASS_AWARE_BOX_NMS_UNIT_MACROS_SVH
`define CLASS_AWARE_BOX_NMS_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CABN_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("box suppression: implication check failed");

// Next-cycle implication, disabled while reset is high.
`define CABN_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("box suppression: next-cycle check failed");

`endif

// File: rtl/cabn_pkg.sv
// Shared constants, types and helpers for the box suppression unit.
// Depends on nothing; cabn_front, cabn_store, cabn_iou, cabn_seq and the top import it.
`default_nettype none
package cabn_pkg;

  localparam int MAX_BOXES  = 64;
  localparam int CLASS_BITS = 7;
  localparam int IDX_W      = $clog2(MAX_BOXES);
  localparam int CNT_W      = $clog2(MAX_BOXES + 1);
  localparam int COORD_W    = 16;
  localparam int SCORE_W    = 16;
  localparam int CLASS_W    = 7;
  localparam int FIFO_DEPTH = 4;
  localparam int FPTR_W     = $clog2(FIFO_DEPTH);
  localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);
  localparam int REG_IDX_W  = 1;
  localparam int REG_W      = 16;
  localparam int AREA_W     = 2 * COORD_W;
  localparam int UNI_W      = AREA_W + 1;
  localparam int PROD_W     = SCORE_W + UNI_W;

  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  localparam reg_idx_t REG_SCORE_THR   = reg_idx_t'(0);
  localparam reg_idx_t REG_OVERLAP_THR = reg_idx_t'(1);

  localparam logic [REG_W-1:0] SCORE_THR_RESET   = 16'd16384;
  localparam logic [REG_W-1:0] OVERLAP_THR_RESET = 16'd29491;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
    logic [SCORE_W-1:0]        score;
    logic [CLASS_BITS-1:0]     cls;
  } box_t;

  localparam int BOX_W = $bits(box_t);

  // One queued input transaction, already classified by the front end.
  typedef struct packed {
    box_t box;
    logic keep;
    logic final_box;
  } item_t;

  typedef struct packed {
    box_t box;
    logic valid_res;
    logic overflow;
    logic last_result;
  } result_t;

  typedef struct packed {
    logic ins;
    logic shift;
    logic clr_ovf;
  } store_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             ovf;
  } store_stat_t;

  // Width of hi - lo when positive, otherwise zero.
  function automatic logic [COORD_W-1:0] span(input logic signed [COORD_W-1:0] lo,
                                              input logic signed [COORD_W-1:0] hi);
    logic signed [COORD_W:0] d;
    d = {hi[COORD_W-1], hi} - {lo[COORD_W-1], lo};
    if (hi > lo) begin
      return d[COORD_W-1:0];
    end
    return '0;
  endfunction

endpackage
`default_nettype wire

// File: rtl/cabn_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the frame's box buffer.
`default_nettype none
module cabn_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// File: rtl/cabn_front.sv
// Front end: classifies incoming boxes against the score threshold and queues them.
// Depends on cabn_pkg.
`default_nettype none
module cabn_front (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        push,
  output      logic                        full,
  input  wire cabn_pkg::box_t              in_box,
  input  wire logic                        in_final,
  input  wire logic [cabn_pkg::REG_W-1:0]  score_thr,
  output      cabn_pkg::item_t             q_item,
  output      logic                        q_valid,
  input  wire logic                        q_pop
);
  import cabn_pkg::*;

  item_t             slots [FIFO_DEPTH];
  logic [FPTR_W-1:0] wr_ptr;
  logic [FPTR_W-1:0] rd_ptr;
  logic [FCNT_W-1:0] fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == FCNT_W'(FIFO_DEPTH));
  assign q_valid = (fill != '0);
  assign do_push = push && !full;
  assign do_pop  = q_pop && q_valid;
  assign q_item  = slots[rd_ptr];

  // Store the classified transaction.
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= '{box: in_box, keep: (in_box.score >= score_thr),
                         final_box: in_final};
    end
  end

  // Queue pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == FPTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/cabn_store.sv
// Score-ordered box store: a shift line that inserts one box per cycle in order.
// Depends on cabn_pkg.
`default_nettype none
module cabn_store (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire cabn_pkg::store_ctrl_t ctrl,
  input  wire cabn_pkg::box_t        new_box,
  output      cabn_pkg::store_stat_t stat,
  output      cabn_pkg::box_t        head
);
  import cabn_pkg::*;

  box_t             entry [MAX_BOXES];
  logic [CNT_W-1:0] count;
  logic             ovf;
  logic [MAX_BOXES-1:0] ge;

  assign stat = '{count: count, ovf: ovf};
  assign head = entry[0];

  // An entry stays put when it is occupied and scores at least the new box.
  always_comb begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      ge[i] = (CNT_W'(i) < count) && (entry[i].score >= new_box.score);
    end
  end

  // Insertion moves lower entries down; unloading moves all entries up.
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_BOXES; i++) begin
      if (ctrl.ins) begin
        if (!ge[i]) begin
          if (i == 0) begin
            entry[i] <= new_box;
          end else if (ge[i-1]) begin
            entry[i] <= new_box;
          end else begin
            entry[i] <= entry[i-1];
          end
        end
      end else if (ctrl.shift && i < MAX_BOXES - 1) begin
        entry[i] <= entry[i+1];
      end
    end
  end

  // Occupancy and the overflow mark.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      ovf   <= 1'b0;
    end else begin
      if (ctrl.ins) begin
        if (count == CNT_W'(MAX_BOXES)) begin
          ovf <= 1'b1;
        end else begin
          count <= count + 1'b1;
        end
      end else if (ctrl.shift && count != '0) begin
        count <= count - 1'b1;
      end
      if (ctrl.clr_ovf) begin
        ovf <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/cabn_iou.sv
// Pipelined overlap test: five stages deciding inter / union > threshold by
// cross-multiplication. Depends on cabn_pkg.
`default_nettype none
module cabn_iou (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  input  wire cabn_pkg::box_t              a,
  input  wire cabn_pkg::box_t              b,
  input  wire logic [cabn_pkg::IDX_W-1:0]  in_tag,
  input  wire logic                        same,
  input  wire logic [cabn_pkg::REG_W-1:0]  thr,
  output      logic                        out_valid,
  output      logic [cabn_pkg::IDX_W-1:0]  out_tag,
  output      logic                        hit,
  output      logic                        busy
);
  import cabn_pkg::*;

  logic v1, v2, v3, v4;
  logic [IDX_W-1:0] tag1, tag2, tag3, tag4;
  logic same1, same2, same3, same4;
  logic [COORD_W-1:0] iw, ih, aw, ah, bw, bh;
  logic [AREA_W-1:0]  inter2, area_a, area_b, inter3;
  logic [UNI_W-1:0]   uni3;
  logic [PROD_W-1:0]  prod4;
  logic [PROD_W-1:0]  inter4;
  logic               nz4;
  logic signed [COORD_W-1:0] il, it, ir, ib;

  // Intersection corners.
  always_comb begin
    il = (a.left > b.left) ? a.left : b.left;
    it = (a.top > b.top) ? a.top : b.top;
    ir = (a.right < b.right) ? a.right : b.right;
    ib = (a.bottom < b.bottom) ? a.bottom : b.bottom;
  end

  // Stage valids.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      out_valid <= v4;
    end
  end

  // Datapath: spans, products, union, scaled union, compare.
  always_ff @(posedge clk) begin
    tag1  <= in_tag;
    same1 <= same;
    iw <= span(il, ir);
    ih <= span(it, ib);
    aw <= span(a.left, a.right);
    ah <= span(a.top, a.bottom);
    bw <= span(b.left, b.right);
    bh <= span(b.top, b.bottom);

    tag2   <= tag1;
    same2  <= same1;
    inter2 <= iw * ih;
    area_a <= aw * ah;
    area_b <= bw * bh;

    tag3   <= tag2;
    same3  <= same2;
    inter3 <= inter2;
    uni3   <= {1'b0, area_a} + {1'b0, area_b} - {1'b0, inter2};

    tag4   <= tag3;
    same4  <= same3;
    nz4    <= (uni3 != '0);
    prod4  <= thr * uni3;
    inter4 <= {1'b0, inter3, {SCORE_W{1'b0}}};

    out_tag <= tag4;
    hit     <= same4 && nz4 && (inter4 > prod4);
  end

  assign busy = v1 || v2 || v3 || v4 || out_valid;

endmodule
`default_nettype wire

// File: rtl/cabn_seq.sv
// Back end sequencer: takes queued boxes into the store, unloads a frame into the
// buffer RAM, runs greedy same-class suppression and emits survivors.
// Depends on cabn_pkg, cabn_ram and cabn_iou.
`default_nettype none
module cabn_seq (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire cabn_pkg::item_t             q_item,
  input  wire logic                        q_valid,
  output      logic                        q_pop,
  output      cabn_pkg::store_ctrl_t       sctrl,
  input  wire cabn_pkg::store_stat_t       sstat,
  input  wire cabn_pkg::box_t              shead,
  input  wire logic [cabn_pkg::REG_W-1:0]  overlap_thr,
  output      cabn_pkg::result_t           res,
  output      logic                        empty,
  input  wire logic                        pop
);
  import cabn_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_LOAD  = 9'b000000010,
    S_HEAD  = 9'b000000100,
    S_HWAIT = 9'b000001000,
    S_SCAN  = 9'b000010000,
    S_DRAIN = 9'b000100000,
    S_EMIT  = 9'b001000000,
    S_EPUT  = 9'b010000000,
    S_FLUSH = 9'b100000000
  } state_t;

  state_t               state, state_next;
  logic [CNT_W-1:0]     k, n, i, j, o;
  logic [MAX_BOXES-1:0] removed;
  logic                 frame_ovf;
  box_t                 head_box, pend;
  logic                 pend_v;
  logic                 out_v;
  logic                 rd_pend;
  logic [IDX_W-1:0]     rd_tag;
  logic                 slot_free;
  logic                 ram_we, ram_re;
  logic [IDX_W-1:0]     ram_raddr;
  box_t                 ram_rdata;
  logic                 iou_valid, iou_hit, iou_busy;
  logic [IDX_W-1:0]     iou_tag;

  assign slot_free = !out_v || pop;
  assign empty     = !out_v;
  assign q_pop     = (state == S_IDLE) && q_valid;

  // Frame buffer.
  cabn_ram #(.WIDTH(BOX_W), .DEPTH(MAX_BOXES)) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (k[IDX_W-1:0]),
    .wdata (shead),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Overlap pipeline fed by the head box and the streamed candidate.
  cabn_iou u_iou (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (rd_pend),
    .a         (head_box),
    .b         (ram_rdata),
    .in_tag    (rd_tag),
    .same      (head_box.cls == ram_rdata.cls),
    .thr       (overlap_thr),
    .out_valid (iou_valid),
    .out_tag   (iou_tag),
    .hit       (iou_hit),
    .busy      (iou_busy)
  );

  // Next state, store control and buffer write and read requests.
  always_comb begin
    state_next    = state;
    sctrl         = '0;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    case (state)
      S_IDLE: begin
        sctrl.ins = q_pop && q_item.keep;
        if (q_pop && q_item.final_box) begin
          state_next = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sstat.count != '0) begin
          ram_we      = 1'b1;
          sctrl.shift = 1'b1;
        end else begin
          sctrl.clr_ovf = 1'b1;
          state_next    = S_HEAD;
        end
      end
      S_HEAD: begin
        if (i + 1'b1 >= n) begin
          state_next = S_EMIT;
        end else if (!removed[i[IDX_W-1:0]]) begin
          ram_re     = 1'b1;
          ram_raddr  = i[IDX_W-1:0];
          state_next = S_HWAIT;
        end
      end
      S_HWAIT: begin
        state_next = S_SCAN;
      end
      S_SCAN: begin
        ram_re    = 1'b1;
        ram_raddr = j[IDX_W-1:0];
        if (j + 1'b1 == n) begin
          state_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (!rd_pend && !iou_busy) begin
          state_next = S_HEAD;
        end
      end
      S_EMIT: begin
        if (o == n) begin
          state_next = S_FLUSH;
        end else if (!removed[o[IDX_W-1:0]]) begin
          ram_re     = 1'b1;
          ram_raddr  = o[IDX_W-1:0];
          state_next = S_EPUT;
        end
      end
      S_EPUT: begin
        if (!pend_v || slot_free) begin
          state_next = S_EMIT;
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      removed <= '0;
      pend_v  <= 1'b0;
      out_v   <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      state   <= state_next;
      rd_pend <= (state == S_SCAN);
      if (iou_valid && iou_hit) begin
        removed[iou_tag] <= 1'b1;
      end
      if (state == S_EPUT && !pend_v) begin
        pend_v <= 1'b1;
      end
      // A new result fills the register; otherwise an accepted one empties it.
      if ((state == S_EPUT && pend_v && slot_free) || (state == S_FLUSH && slot_free)) begin
        out_v <= 1'b1;
      end else if (pop && out_v) begin
        out_v <= 1'b0;
      end
      if (state == S_FLUSH && slot_free) begin
        pend_v  <= 1'b0;
        removed <= '0;
      end
    end
  end

  // Counters, latched boxes and the result register.
  always_ff @(posedge clk) begin
    rd_tag <= j[IDX_W-1:0];
    case (state)
      S_IDLE: begin
        k <= '0;
      end
      S_LOAD: begin
        if (sstat.count != '0) begin
          k <= k + 1'b1;
        end else begin
          n         <= k;
          i         <= '0;
          frame_ovf <= sstat.ovf;
        end
      end
      S_HEAD: begin
        if (i + 1'b1 >= n) begin
          o <= '0;
        end else if (removed[i[IDX_W-1:0]]) begin
          i <= i + 1'b1;
        end
      end
      S_HWAIT: begin
        head_box <= ram_rdata;
        j        <= i + 1'b1;
      end
      S_SCAN: begin
        j <= j + 1'b1;
      end
      S_DRAIN: begin
        if (!rd_pend && !iou_busy) begin
          i <= i + 1'b1;
        end
      end
      S_EMIT: begin
        if (o != n && removed[o[IDX_W-1:0]]) begin
          o <= o + 1'b1;
        end
      end
      S_EPUT: begin
        if (!pend_v || slot_free) begin
          pend <= ram_rdata;
          o    <= o + 1'b1;
        end
        if (pend_v && slot_free) begin
          res <= '{box: pend, valid_res: 1'b1, overflow: frame_ovf, last_result: 1'b0};
        end
      end
      S_FLUSH: begin
        if (slot_free) begin
          if (pend_v) begin
            res <= '{box: pend, valid_res: 1'b1, overflow: frame_ovf,
                     last_result: 1'b1};
          end else begin
            res <= '{box: '0, valid_res: 1'b0, overflow: frame_ovf, last_result: 1'b1};
          end
        end
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/class_aware_box_nms_unit.sv
// Per-class greedy box suppression. Boxes enter on a queue-style port
// (push/full); surviving boxes leave on a queue-style port (empty/pop) in
// descending score order, ties in arrival order. Boxes below score_threshold
// are dropped; at most MAX_BOXES are kept, extra ones set the overflow flag.
// A box with final_box set closes the frame: once it is taken in, the frame
// is suppressed and emitted, the last transaction carrying last_result. A
// frame with no survivor yields one transaction with valid_res low.
// A non-final box is queued, then inserted into the store, so one box per
// cycle is sustained while the back end is idle. On the final box the back
// end copies the n kept boxes into the buffer RAM, then for each still-kept
// head box i streams candidates i + 1 to n - 1 through the five-stage
// overlap pipeline, then emits the survivors; streaming and emission share
// the single read port of the buffer RAM. A four-entry input queue keeps
// taking boxes meanwhile. A stalled receiver holds the result register and
// pauses emission. Reset clears the store, the queues and restores both
// thresholds.
// Depends on cabn_pkg, cabn_front, cabn_store, cabn_seq and the macro header.
`default_nettype none
`include "class_aware_box_nms_unit_macros.svh"
module class_aware_box_nms_unit (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             push,
  output      logic                             full,
  input  wire logic signed [cabn_pkg::COORD_W-1:0] left,
  input  wire logic signed [cabn_pkg::COORD_W-1:0] top,
  input  wire logic signed [cabn_pkg::COORD_W-1:0] right,
  input  wire logic signed [cabn_pkg::COORD_W-1:0] bottom,
  input  wire logic [cabn_pkg::SCORE_W-1:0]     score,
  input  wire logic [cabn_pkg::CLASS_W-1:0]     class_id,
  input  wire logic                             final_box,
  output      logic                             empty,
  input  wire logic                             pop,
  output      logic signed [cabn_pkg::COORD_W-1:0] out_left,
  output      logic signed [cabn_pkg::COORD_W-1:0] out_top,
  output      logic signed [cabn_pkg::COORD_W-1:0] out_right,
  output      logic signed [cabn_pkg::COORD_W-1:0] out_bottom,
  output      logic [cabn_pkg::SCORE_W-1:0]     out_score,
  output      logic [cabn_pkg::CLASS_W-1:0]     out_class,
  output      logic                             valid_res,
  output      logic                             overflow,
  output      logic                             last_result,
  input  wire logic                             wr_en,
  input  wire cabn_pkg::reg_idx_t               wr_index,
  input  wire logic [cabn_pkg::REG_W-1:0]       wr_data
);
  import cabn_pkg::*;

  logic [REG_W-1:0] score_thr;
  logic [REG_W-1:0] overlap_thr;
  box_t             in_box;
  item_t            q_item;
  logic             q_valid, q_pop;
  store_ctrl_t      sctrl;
  store_stat_t      sstat;
  box_t             shead;
  result_t          res;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      score_thr   <= SCORE_THR_RESET;
      overlap_thr <= OVERLAP_THR_RESET;
    end else if (wr_en) begin
      case (wr_index)
        REG_SCORE_THR:   score_thr   <= wr_data;
        REG_OVERLAP_THR: overlap_thr <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign in_box = '{left: left, top: top, right: right, bottom: bottom,
                    score: score, cls: CLASS_BITS'(class_id)};

  cabn_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .in_box    (in_box),
    .in_final  (final_box),
    .score_thr (score_thr),
    .q_item    (q_item),
    .q_valid   (q_valid),
    .q_pop     (q_pop)
  );

  cabn_store u_store (
    .clk     (clk),
    .rst     (rst),
    .ctrl    (sctrl),
    .new_box (q_item.box),
    .stat    (sstat),
    .head    (shead)
  );

  cabn_seq u_seq (
    .clk         (clk),
    .rst         (rst),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_pop       (q_pop),
    .sctrl       (sctrl),
    .sstat       (sstat),
    .shead       (shead),
    .overlap_thr (overlap_thr),
    .res         (res),
    .empty       (empty),
    .pop         (pop)
  );

  // Result fields.
  assign out_left    = res.box.left;
  assign out_top     = res.box.top;
  assign out_right   = res.box.right;
  assign out_bottom  = res.box.bottom;
  assign out_score   = res.box.score;
  assign out_class   = CLASS_W'(res.box.cls);
  assign valid_res   = res.valid_res;
  assign overflow    = res.overflow;
  assign last_result = res.last_result;

  // The store never holds more than its capacity.
  `CABN_ASSERT_IMP(a_count_bound, 1'b1, sstat.count <= CNT_W'(MAX_BOXES))
  // An empty-frame transaction is always the frame's last.
  `CABN_ASSERT_IMP(a_empty_is_last, !empty && !valid_res, last_result)
  // Inserting into a full store records the overflow.
  `CABN_ASSERT_NXT(a_ovf_set, sctrl.ins && sstat.count == CNT_W'(MAX_BOXES), sstat.ovf)

endmodule
`default_nettype wire

// File: dv/class_aware_box_nms_unit_tb.sv
// Testbench for the per-class box suppression unit: drives frames of boxes,
// predicts the surviving boxes in a scoreboard class and checks every result.
// Depends on cabn_pkg and the class_aware_box_nms_unit RTL.
`default_nettype none
module class_aware_box_nms_unit_tb;
  import cabn_pkg::*;

  typedef struct {
    logic signed [15:0] l, t, r, b;
    logic [15:0] sc;
    logic [6:0] cl;
    logic vr, ovf, lr;
  } survivor_t;

  // Scoreboard: keeps its own copy of the score-ordered store and thresholds.
  class nms_scoreboard;
    logic [15:0] score_thr = SCORE_THR_RESET;
    logic [15:0] overlap_thr = OVERLAP_THR_RESET;
    survivor_t kept[$];
    bit frame_ovf;
    survivor_t pending[$];
    int errors;
    int mismatches;

    function automatic longint width_of(int lo, int hi);
      return hi > lo ? longint'(hi - lo) : 0;
    endfunction

    // Cross-multiplied IoU test with clamped intersection.
    function automatic bit too_close(survivor_t a, survivor_t b);
      longint ia, ua;
      int il, it, ir, ib;
      il = a.l > b.l ? a.l : b.l;
      it = a.t > b.t ? a.t : b.t;
      ir = a.r < b.r ? a.r : b.r;
      ib = a.b < b.b ? a.b : b.b;
      ia = width_of(il, ir) * width_of(it, ib);
      ua = width_of(a.l, a.r) * width_of(a.t, a.b)
         + width_of(b.l, b.r) * width_of(b.t, b.b) - ia;
      if (ua == 0) return 0;
      return (ia << 16) > longint'(overlap_thr) * ua;
    endfunction

    // Notes one accepted input transaction.
    function void note_box(survivor_t bx, bit fin);
      int p;
      bit gone[$];
      int n;
      p = 0;
      if (bx.sc >= score_thr) begin
        while (p < kept.size() && kept[p].sc >= bx.sc) p++;
        if (kept.size() < MAX_BOXES) kept.insert(p, bx);
        else begin
          frame_ovf = 1;
          if (p < MAX_BOXES) begin
            kept.insert(p, bx);
            void'(kept.pop_back());
          end
        end
      end
      if (!fin) return;
      n = kept.size();
      for (int i = 0; i < n; i++) gone.push_back(0);
      for (int i = 0; i < n; i++) begin
        if (gone[i]) continue;
        for (int j = i + 1; j < n; j++)
          if (!gone[j] && kept[i].cl == kept[j].cl && too_close(kept[i], kept[j]))
            gone[j] = 1;
      end
      p = pending.size();
      for (int i = 0; i < n; i++) begin
        if (gone[i]) continue;
        bx = kept[i];
        bx.vr = 1; bx.ovf = frame_ovf; bx.lr = 0;
        pending.push_back(bx);
      end
      if (pending.size() == p) begin
        bx = '{default: 0};
        bx.ovf = frame_ovf;
        pending.push_back(bx);
      end
      pending[pending.size() - 1].lr = 1;
      kept.delete();
      frame_ovf = 0;
    endfunction

    // Compares one accepted result transaction against the oldest expectation.
    function void check_result(survivor_t got);
      survivor_t e;
      if (pending.size() == 0) begin
        errors++;
        if (mismatches++ < 10) $display("ERROR: unexpected result transaction");
        return;
      end
      e = pending.pop_front();
      if (e.l !== got.l || e.t !== got.t || e.r !== got.r || e.b !== got.b ||
          e.sc !== got.sc || e.cl !== got.cl || e.vr !== got.vr ||
          e.ovf !== got.ovf || e.lr !== got.lr) begin
        errors++;
        if (mismatches++ < 10)
          $display({"ERROR: exp %0d %0d %0d %0d s%0d c%0d v%0d o%0d l%0d, ",
                    "got %0d %0d %0d %0d s%0d c%0d v%0d o%0d l%0d"},
                   e.l, e.t, e.r, e.b, e.sc, e.cl, e.vr, e.ovf, e.lr,
                   got.l, got.t, got.r, got.b, got.sc, got.cl, got.vr, got.ovf, got.lr);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic push = 0, pop = 0, wr_en = 0, final_box = 0;
  logic full, empty, valid_res, overflow, last_result;
  logic signed [15:0] left = 0, top = 0, right = 0, bottom = 0;
  logic signed [15:0] out_left, out_top, out_right, out_bottom;
  logic [15:0] score = 0, out_score, wr_data = 0;
  logic [6:0] class_id = 0, out_class;
  reg_idx_t wr_index = REG_SCORE_THR;
  nms_scoreboard sb = new();
  bit calm = 0;
  bit tx_done = 0;
  int idle_cycles = 0;

  class_aware_box_nms_unit dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Result side: random pop stalls, every accepted transaction is checked.
  always @(posedge clk) begin
    survivor_t got;
    if (!rst && pop && !empty) begin
      got.l = out_left; got.t = out_top; got.r = out_right; got.b = out_bottom;
      got.sc = out_score; got.cl = out_class; got.vr = valid_res;
      got.ovf = overflow; got.lr = last_result;
      sb.check_result(got);
    end
    pop <= calm || ($urandom_range(99) >= 16);
  end

  // Watchdog on cycles without any accepted transaction.
  always @(posedge clk) begin
    if ((push && !full) || (pop && !empty) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 50000) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // Push stays high after acceptance so boxes can follow back to back.
  task automatic send_box(int l, int t, int r, int b, int s, int c, bit fin);
    survivor_t bx;
    while (!calm && $urandom_range(99) < 16) begin
      push <= 0;
      @(posedge clk);
    end
    push <= 1; left <= 16'(l); top <= 16'(t); right <= 16'(r); bottom <= 16'(b);
    score <= 16'(s); class_id <= 7'(c); final_box <= fin;
    do @(posedge clk); while (full);
    bx = '{default: 0};
    bx.l = 16'(l); bx.t = 16'(t); bx.r = 16'(r); bx.b = 16'(b);
    bx.sc = 16'(s); bx.cl = 7'(c);
    sb.note_box(bx, fin);
  endtask

  // Waits until all results are in, plus settle time, then writes a register.
  task automatic write_reg(reg_idx_t idx, logic [15:0] val);
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    wr_en <= 1; wr_index <= idx; wr_data <= val;
    @(posedge clk);
    wr_en <= 0;
    if (idx == REG_SCORE_THR) sb.score_thr = val;
    else sb.overlap_thr = val;
  endtask

  task automatic rand_box(bit fin, int cls_max, int spread);
    int l, t;
    l = $urandom_range(2 * spread) - spread;
    t = $urandom_range(2 * spread) - spread;
    send_box(l, t, l + $urandom_range(spread) - 8, t + $urandom_range(spread) - 8,
             $urandom_range(65535), $urandom_range(cls_max), fin);
  endtask

  initial begin
    int nb;
    repeat (7) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    // Directed: extremes, duplicates, inverted boxes, ties, empty frame.
    send_box(-32768, -32768, 32767, 32767, 65535, 127, 0);
    send_box(-32768, -32768, 32767, 32767, 65535, 127, 0);
    send_box(0, 0, 160, 160, 30000, 5, 0);
    send_box(16, 16, 176, 176, 30000, 5, 0);
    send_box(100, 100, 50, 50, 40000, 5, 0);
    send_box(0, 0, 160, 160, 20000, 6, 0);
    send_box(5, 5, 5, 5, 20000, 6, 0);
    send_box(0, 0, 10, 10, 16383, 1, 0);
    send_box(0, 0, 10, 10, 16384, 1, 1);
    send_box(0, 0, 10, 10, 100, 0, 1);
    write_reg(REG_SCORE_THR, 16'd0);
    write_reg(REG_OVERLAP_THR, 16'd0);
    send_box(0, 0, 100, 100, 0, 0, 0);
    send_box(99, 99, 200, 200, 0, 0, 1);
    write_reg(REG_OVERLAP_THR, 16'd65535);
    send_box(0, 0, 100, 100, 1, 2, 0);
    send_box(0, 0, 100, 100, 1, 2, 1);
    write_reg(REG_SCORE_THR, 16'd65535);
    send_box(0, 0, 1, 1, 65534, 3, 0);
    send_box(-1, -1, 0, 0, 65535, 3, 1);
    write_reg(REG_SCORE_THR, 16'd0);
    write_reg(REG_OVERLAP_THR, OVERLAP_THR_RESET);
    // Overflow frame: store filled past capacity.
    for (int i = 0; i < 70; i++) rand_box(i == 69, 3, 200);
    // Random frames of small size with varying thresholds.
    for (int f = 0; f < 6; f++) begin
      calm = (f >= 2 && f < 4);
      if (f % 4 == 3) begin
        write_reg(REG_SCORE_THR, 16'($urandom_range(40000)));
        write_reg(REG_OVERLAP_THR, 16'($urandom_range(65535)));
      end
      nb = $urandom_range(8, 1);
      for (int i = 0; i < nb; i++) rand_box(i == nb - 1, (f % 2) ? 3 : 127,
                                              (f % 3 == 0) ? 32000 : 300);
    end
    calm = 0;
    push <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (sb.errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end
endmodule
`default_nettype wire
